// ----- rtl/epair_pkg.sv -----
// Shared types and constants for the elegant pairing encode/decode block.
`timescale 1ns / 1ps

package epair_pkg;

  // Component width as built by default, and the fixed port field widths.
  localparam int unsigned CompBitsDef = 32;
  localparam int unsigned CompPortBits = 32;
  localparam int unsigned CodePortBits = 64;

  // Operation codes carried in func and op_echo.
  typedef enum logic {
    OP_PAIR   = 1'b0,
    OP_UNPAIR = 1'b1
  } op_e;

  // One request beat.
  typedef struct packed {
    logic                    func;
    logic [CompPortBits-1:0] first_in;
    logic [CompPortBits-1:0] second_in;
    logic [CodePortBits-1:0] code_in;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [CodePortBits-1:0] code_out;
    logic [CompPortBits-1:0] first_out;
    logic [CompPortBits-1:0] second_out;
    logic                    op_echo;
  } rsp_t;

endpackage

// ----- rtl/elegant_pairing_encode_decode_top.sv -----
// Top level of the elegant pairing encode/decode block: pair and unpair pipeline.
//
//   Channel   Ports                  Handshake
//   request   start, busy, req_i     beat taken when start is high and busy is low
//   result    done_o, rsp_o          beat valid for the one cycle done_o is high
//
// A request beat can be taken in every cycle; busy stays low.
// The result passes through one input register, one root stage per two root bits (the pair
// path runs beside it), and one output register.
// Reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot hold results off, so the pipeline never stalls.
`timescale 1ns / 1ps

module elegant_pairing_encode_decode_top import epair_pkg::*; #(
  parameter int unsigned CompBits = CompBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned CodeBits  = 2 * CompBits;
  localparam int unsigned NumStages = (CompBits + 1) / 2;
  localparam int unsigned Latency   = NumStages + 2;

  // The pipeline takes a beat every cycle.
  assign busy = 1'b0;

  // Input register with masking to the configured widths.
  logic                s0_vld_q;
  logic                s0_op_q;
  logic [CompBits-1:0] s0_x_q;
  logic [CompBits-1:0] s0_y_q;
  logic [CodeBits-1:0] s0_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_op_q <= req_i.func;
    s0_x_q  <= req_i.first_in[CompBits-1:0];
    s0_y_q  <= req_i.second_in[CompBits-1:0];
    s0_z_q  <= req_i.code_in[CodeBits-1:0];
  end

  // Pair, first step: square the larger term and form the addend.
  logic [CompBits-1:0] big;
  logic [CodeBits-1:0] sq_d, sq_q;
  logic [CompBits:0]   add_d, add_q;

  always_comb begin
    if (s0_y_q > s0_x_q) begin
      big   = s0_y_q;
      add_d = {1'b0, s0_x_q};
    end else begin
      big   = s0_x_q;
      add_d = {1'b0, s0_x_q} + {1'b0, s0_y_q};
    end
    sq_d = CodeBits'(big) * CodeBits'(big);
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    add_q <= add_d;
  end

  // Valid and operation bits travel beside the root stages.
  logic                vld_q [NumStages];
  logic                op_q  [NumStages];
  logic [CodeBits-1:0] pc_q  [NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < NumStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= s0_vld_q;
      for (int unsigned k = 1; k < NumStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Pair, second step: final add, then the code waits for the root stages.
  always_ff @(posedge clk_i) begin
    op_q[0] <= s0_op_q;
    for (int unsigned k = 1; k < NumStages; k++) begin
      op_q[k] <= op_q[k-1];
    end
    pc_q[0] <= sq_q + CodeBits'(add_q);
    for (int unsigned k = 1; k < NumStages - 1; k++) begin
      pc_q[k] <= pc_q[k-1];
    end
  end

  // Square root of the code.
  logic [CompBits-1:0] root;
  logic [CompBits:0]   rem;

  epair_root_pipe #(
    .CompBits(CompBits)
  ) u_root (
    .clk_i (clk_i),
    .z_i   (s0_z_q),
    .root_o(root),
    .rem_o (rem)
  );

  // Result assembly: unpair picks the component order from the remainder.
  rsp_t              rsp_d;
  logic [CompBits:0] diff;
  logic              op_last;

  assign op_last = op_q[NumStages-1];
  assign diff    = rem - {1'b0, root};

  always_comb begin
    rsp_d         = '0;
    rsp_d.op_echo = op_last;
    if (op_last == OP_UNPAIR) begin
      if (rem < {1'b0, root}) begin
        rsp_d.first_out  = CompPortBits'(rem[CompBits-1:0]);
        rsp_d.second_out = CompPortBits'(root);
      end else begin
        rsp_d.first_out  = CompPortBits'(root);
        rsp_d.second_out = CompPortBits'(diff[CompBits-1:0]);
      end
    end else begin
      rsp_d.code_out = CodePortBits'(pc_q[NumStages-2]);
    end
  end

  // Output register.
  logic done_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Every result beat matches an earlier request beat.
  a_done_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result beat without a matching request beat");

  // A pair result carries no components.
  a_pair_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.op_echo == OP_PAIR) |->
      (rsp_o.first_out == '0 && rsp_o.second_out == '0))
    else $error("pair result with nonzero components");

  // An unpair result carries no code.
  a_unpair_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.op_echo == OP_UNPAIR) |-> (rsp_o.code_out == '0))
    else $error("unpair result with nonzero code");

  // Unpaired components fit the configured component width.
  a_unpair_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.op_echo == OP_UNPAIR) |->
      ((CodePortBits'(rsp_o.first_out) >> CompBits) == '0 &&
       (CodePortBits'(rsp_o.second_out) >> CompBits) == '0))
    else $error("unpair component exceeds component width");

endmodule

// ----- rtl/epair_root_pipe.sv -----
// Pipelined restoring integer square root, two result bits per stage.
`timescale 1ns / 1ps

module epair_root_pipe import epair_pkg::*; #(
  parameter int unsigned CompBits = CompBitsDef
) (
  input  logic                  clk_i,
  input  logic [2*CompBits-1:0] z_i,
  output logic [CompBits-1:0]   root_o,
  output logic [CompBits:0]     rem_o
);

  localparam int unsigned CodeBits      = 2 * CompBits;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NumStages     = (CompBits + StepsPerStage - 1) / StepsPerStage;

  logic [CodeBits-1:0] rem_in  [NumStages];
  logic [CodeBits-1:0] root_in [NumStages];
  logic [CodeBits-1:0] rem_d   [NumStages];
  logic [CodeBits-1:0] root_d  [NumStages];
  logic [CodeBits-1:0] rem_q   [NumStages];
  logic [CodeBits-1:0] root_q  [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    // Stage inputs come from the code for the first stage, else from the stage before.
    if (s == 0) begin : g_first
      assign rem_in[s]  = z_i;
      assign root_in[s] = '0;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
    end

    // Up to two trial subtractions, one per remaining root bit; the trial bit of each iteration is a constant.
    always_comb begin : p_step
      logic [CodeBits-1:0] r;
      logic [CodeBits-1:0] rt;
      logic [CodeBits-1:0] trial;
      logic [CodeBits-1:0] bitv;
      int unsigned         idx;
      r  = rem_in[s];
      rt = root_in[s];
      for (int unsigned j = 0; j < StepsPerStage; j++) begin
        idx = StepsPerStage * s + j;
        if (idx < CompBits) begin
          bitv  = CodeBits'(1) << (CodeBits - 2 - 2 * idx);
          trial = rt + bitv;
          if (r >= trial) begin
            r  = r - trial;
            rt = (rt >> 1) + bitv;
          end else begin
            rt = rt >> 1;
          end
        end
      end
      rem_d[s]  = r;
      root_d[s] = rt;
    end

    // Stage register.
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
    end
  end

  // The final root is below 2^CompBits and the remainder at most twice the root.
  assign root_o = root_q[NumStages-1][CompBits-1:0];
  assign rem_o  = rem_q[NumStages-1][CompBits:0];

endmodule
